// ----- rtl/fpa_pkg.sv -----
// fpa_pkg: opcodes, constants and pipeline payload type of the fixed-point alu
// no dependencies; used by fpa_div_stage, fixed_point_alu and tb_top
`timescale 1ns / 1ps

package fpa_pkg;

    localparam int WORD_W        = 32;
    localparam int FRAC_BITS_DEF = 8;
    localparam int DIV_STEPS     = WORD_W;
    localparam int IN_TDATA_W    = 72;
    localparam int OUT_TDATA_W   = 40;

    localparam logic signed [WORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_EQ       = 4'd4,
        CMD_NE       = 4'd5,
        CMD_LT       = 4'd6,
        CMD_LE       = 4'd7,
        CMD_GT       = 4'd8,
        CMD_GE       = 4'd9,
        CMD_MIN      = 4'd10,
        CMD_MAX      = 4'd11,
        CMD_INCR     = 4'd12,
        CMD_FROM_INT = 4'd13,
        CMD_TO_INT   = 4'd14
    } cmd_t;

    // payload carried down the pipeline
    typedef struct packed {
        logic [3:0]               op;
        logic signed [WORD_W-1:0] res;
        logic                     cmp;
        logic                     ov;
        logic                     dz;
        logic                     neg;      // quotient sign
        logic                     div_ovf;  // quotient known to exceed 32 bits
        logic [WORD_W-1:0]        rem;      // partial remainder
        logic [WORD_W-1:0]        den;      // divisor magnitude
        logic [WORD_W-1:0]        quo;      // numerator bits in, quotient bits out
    } pl_t;

endpackage

// ----- rtl/fpa_div_stage.sv -----
// fpa_div_stage: one registered restoring-division step, one quotient bit
// depends on fpa_pkg
`timescale 1ns / 1ps

module fpa_div_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fpa_pkg::pl_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output fpa_pkg::pl_t  out_data
);
    import fpa_pkg::*;

    logic        valid_reg;
    pl_t         data_reg;
    pl_t         data_next;
    logic [WORD_W:0] trial;
    logic [WORD_W:0] diff;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next = in_data;
        trial     = {in_data.rem, in_data.quo[WORD_W-1]};
        diff      = trial - {1'b0, in_data.den};
        if (trial >= {1'b0, in_data.den})
        begin
            data_next.rem = diff[WORD_W-1:0];
            data_next.quo = {in_data.quo[WORD_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem = trial[WORD_W-1:0];
            data_next.quo = {in_data.quo[WORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/fixed_point_alu.sv -----
// fixed_point_alu: pipelined signed 32-bit fixed-point arithmetic unit
// depends on fpa_pkg and fpa_div_stage
`timescale 1ns / 1ps

// Signed 32-bit fixed-point unit with FRAC_BITS fraction bits. Each request
// carries an opcode and two raw operands and gives exactly one result. One
// request enters per cycle unless the pipeline is stalled; the stages are the
// input register, operand prep with the 32x32 magnitude multiply, multiply
// rounding, 32 restoring division stages at one quotient bit each and the
// output register, the same path for every opcode so results leave in order.
// Every stage has its own valid bit and holds only while the stage after it
// is full and stalled, so bubbles close up and the input keeps taking
// requests while a result waits. Multiply and divide round half away from
// zero; out-of-range results saturate and set overflowed. Division by zero
// gives the maximum or minimum by the sign of operand_a with divide_by_zero
// set and overflowed clear. Opcode 15 gives all zeros.
module fixed_point_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cmd[3:0], operand_a[35:4], operand_b[67:36], zero fill
    input  logic [fpa_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // result_value[31:0], compare_true[32], overflowed[33],
    // divide_by_zero[34], zero fill
    output logic [fpa_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import fpa_pkg::*;

    localparam int NUM_W = WORD_W + FRAC_BITS;

    // input register
    logic                     a_valid_reg;
    logic                     a_ready;
    logic [3:0]               a_cmd_reg;
    logic signed [WORD_W-1:0] a_opa_reg;
    logic signed [WORD_W-1:0] a_opb_reg;

    // prep stage
    logic                     b_valid_reg;
    logic                     b_ready;
    pl_t                      b_pl_reg;
    pl_t                      b_pl_next;
    logic [2*WORD_W-1:0]      b_prod_reg;
    logic [2*WORD_W-1:0]      b_prod_next;

    // multiply rounding stage
    logic                     c_valid_reg;
    logic                     c_ready;
    pl_t                      c_pl_reg;
    pl_t                      c_pl_next;

    // division chain
    logic                     dv_valid [DIV_STEPS+1];
    logic                     dv_ready [DIV_STEPS+1];
    pl_t                      dv_data  [DIV_STEPS+1];

    // output register
    logic                     o_valid_reg;
    logic                     o_ready;
    logic signed [WORD_W-1:0] o_res_reg;
    logic                     o_cmp_reg;
    logic                     o_ov_reg;
    logic                     o_dz_reg;
    logic signed [WORD_W-1:0] o_res_next;
    logic                     o_ov_next;

    // prep working signals
    logic [WORD_W-1:0]        mag_a;
    logic [WORD_W-1:0]        mag_b;
    logic [NUM_W-1:0]         num;
    logic [WORD_W-1:0]        num_hi;
    logic signed [WORD_W:0]   sum_ab;
    logic signed [WORD_W:0]   diff_ab;
    logic signed [2*WORD_W-1:0] shl_a;

    // rounding working signals
    logic [2*WORD_W-1:0]      mul_q;
    logic [WORD_W:0]          div_q;

    // ---------------------------------------------------------------- input
    assign s_tready = !a_valid_reg || a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            a_cmd_reg <= s_tdata[3:0];
            a_opa_reg <= s_tdata[35:4];
            a_opb_reg <= s_tdata[67:36];
        end
    end

    // ----------------------------------------------------------------- prep
    assign a_ready = !b_valid_reg || b_ready;

    always_comb
    begin
        mag_a   = a_opa_reg[WORD_W-1] ? (~a_opa_reg + 1'b1) : a_opa_reg;
        mag_b   = a_opb_reg[WORD_W-1] ? (~a_opb_reg + 1'b1) : a_opb_reg;
        num     = {mag_a, {FRAC_BITS{1'b0}}};
        num_hi  = {{(WORD_W-FRAC_BITS){1'b0}}, num[NUM_W-1:WORD_W]};
        sum_ab  = {a_opa_reg[WORD_W-1], a_opa_reg} + {a_opb_reg[WORD_W-1], a_opb_reg};
        diff_ab = {a_opa_reg[WORD_W-1], a_opa_reg} - {a_opb_reg[WORD_W-1], a_opb_reg};
        shl_a   = {{WORD_W{a_opa_reg[WORD_W-1]}}, a_opa_reg} <<< FRAC_BITS;

        b_prod_next       = mag_a * mag_b;
        b_pl_next         = '0;
        b_pl_next.op      = a_cmd_reg;
        b_pl_next.neg     = a_opa_reg[WORD_W-1] ^ a_opb_reg[WORD_W-1];
        b_pl_next.den     = mag_b;
        b_pl_next.rem     = num_hi;
        b_pl_next.quo     = num[WORD_W-1:0];
        b_pl_next.div_ovf = num_hi >= mag_b;

        unique case (cmd_t'(a_cmd_reg))
            CMD_ADD, CMD_SUB:
            begin
                if (a_cmd_reg == CMD_ADD)
                begin
                    b_pl_next.res = sum_ab[WORD_W-1:0];
                    if (sum_ab[WORD_W] != sum_ab[WORD_W-1])
                    begin
                        b_pl_next.ov  = 1'b1;
                        b_pl_next.res = sum_ab[WORD_W] ? SAT_MIN : SAT_MAX;
                    end
                end
                else
                begin
                    b_pl_next.res = diff_ab[WORD_W-1:0];
                    if (diff_ab[WORD_W] != diff_ab[WORD_W-1])
                    begin
                        b_pl_next.ov  = 1'b1;
                        b_pl_next.res = diff_ab[WORD_W] ? SAT_MIN : SAT_MAX;
                    end
                end
            end
            CMD_MUL:
            begin
                // finished in the rounding stage
            end
            CMD_DIV:
            begin
                if (mag_b == '0)
                begin
                    b_pl_next.dz  = 1'b1;
                    b_pl_next.res = a_opa_reg[WORD_W-1] ? SAT_MIN : SAT_MAX;
                end
            end
            CMD_EQ:  b_pl_next.cmp = a_opa_reg == a_opb_reg;
            CMD_NE:  b_pl_next.cmp = a_opa_reg != a_opb_reg;
            CMD_LT:  b_pl_next.cmp = a_opa_reg <  a_opb_reg;
            CMD_LE:  b_pl_next.cmp = a_opa_reg <= a_opb_reg;
            CMD_GT:  b_pl_next.cmp = a_opa_reg >  a_opb_reg;
            CMD_GE:  b_pl_next.cmp = a_opa_reg >= a_opb_reg;
            CMD_MIN: b_pl_next.res = (a_opa_reg > a_opb_reg) ? a_opb_reg : a_opa_reg;
            CMD_MAX: b_pl_next.res = (a_opa_reg < a_opb_reg) ? a_opb_reg : a_opa_reg;
            CMD_INCR:
            begin
                if (a_opa_reg == SAT_MAX)
                begin
                    b_pl_next.ov  = 1'b1;
                    b_pl_next.res = SAT_MAX;
                end
                else
                begin
                    b_pl_next.res = a_opa_reg + 1'b1;
                end
            end
            CMD_FROM_INT:
            begin
                if (shl_a > 64'sh7FFF_FFFF)
                begin
                    b_pl_next.ov  = 1'b1;
                    b_pl_next.res = SAT_MAX;
                end
                else if (shl_a < -64'sh8000_0000)
                begin
                    b_pl_next.ov  = 1'b1;
                    b_pl_next.res = SAT_MIN;
                end
                else
                begin
                    b_pl_next.res = shl_a[WORD_W-1:0];
                end
            end
            CMD_TO_INT: b_pl_next.res = a_opa_reg >>> FRAC_BITS;
            default:
            begin
                // unused opcode gives all zeros
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && a_valid_reg)
        begin
            b_pl_reg   <= b_pl_next;
            b_prod_reg <= b_prod_next;
        end
    end

    // ------------------------------------------------------ multiply rounding
    assign b_ready = !c_valid_reg || c_ready;

    always_comb
    begin
        c_pl_next = b_pl_reg;
        mul_q     = (b_prod_reg + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (b_pl_reg.op == CMD_MUL)
        begin
            if (!b_pl_reg.neg && mul_q > 64'h7FFF_FFFF)
            begin
                c_pl_next.ov  = 1'b1;
                c_pl_next.res = SAT_MAX;
            end
            else if (b_pl_reg.neg && mul_q > 64'h8000_0000)
            begin
                c_pl_next.ov  = 1'b1;
                c_pl_next.res = SAT_MIN;
            end
            else if (b_pl_reg.neg)
            begin
                c_pl_next.res = ~mul_q[WORD_W-1:0] + 1'b1;
            end
            else
            begin
                c_pl_next.res = mul_q[WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && b_valid_reg)
        begin
            c_pl_reg <= c_pl_next;
        end
    end

    // ------------------------------------------------------- division chain
    assign dv_valid[0] = c_valid_reg;
    assign dv_data[0]  = c_pl_reg;
    assign c_ready     = dv_ready[0];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        fpa_div_stage u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[k]),
            .in_ready  (dv_ready[k]),
            .in_data   (dv_data[k]),
            .out_valid (dv_valid[k+1]),
            .out_ready (dv_ready[k+1]),
            .out_data  (dv_data[k+1])
        );
    end

    assign dv_ready[DIV_STEPS] = o_ready;

    // --------------------------------------------------------------- output
    assign o_ready = !o_valid_reg || m_tready;

    always_comb
    begin
        o_res_next = dv_data[DIV_STEPS].res;
        o_ov_next  = dv_data[DIV_STEPS].ov;
        // round up when twice the remainder reaches the divisor
        div_q = {1'b0, dv_data[DIV_STEPS].quo}
              + {{WORD_W{1'b0}},
                 ({dv_data[DIV_STEPS].rem, 1'b0} >= {1'b0, dv_data[DIV_STEPS].den})};
        if (dv_data[DIV_STEPS].op == CMD_DIV && !dv_data[DIV_STEPS].dz)
        begin
            if (dv_data[DIV_STEPS].div_ovf
                || (!dv_data[DIV_STEPS].neg && div_q > 33'h0_7FFF_FFFF)
                || (dv_data[DIV_STEPS].neg && div_q > 33'h0_8000_0000))
            begin
                o_ov_next  = 1'b1;
                o_res_next = dv_data[DIV_STEPS].neg ? SAT_MIN : SAT_MAX;
            end
            else if (dv_data[DIV_STEPS].neg)
            begin
                o_res_next = ~div_q[WORD_W-1:0] + 1'b1;
            end
            else
            begin
                o_res_next = div_q[WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ready)
        begin
            o_valid_reg <= dv_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && dv_valid[DIV_STEPS])
        begin
            o_res_reg <= o_res_next;
            o_cmp_reg <= dv_data[DIV_STEPS].cmp;
            o_ov_reg  <= o_ov_next;
            o_dz_reg  <= dv_data[DIV_STEPS].dz;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {5'd0, o_dz_reg, o_ov_reg, o_cmp_reg, o_res_reg};

    // ----------------------------------------------------------- assertions
    // divide by zero never also reports overflow
    a_dz_no_ov: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34] |-> !m_tdata[33])
        else $error("divide by zero flagged together with overflow");

    // a true comparison carries a zero result and no flags
    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] |-> m_tdata[31:0] == '0 && !m_tdata[33] && !m_tdata[34])
        else $error("comparison result not clean");

    // saturation always lands on a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33] || m_tdata[34])
        |-> m_tdata[31:0] == SAT_MAX || m_tdata[31:0] == SAT_MIN)
        else $error("saturated result is not a range limit");

    // a stalled stage at the end of the division chain is held, not dropped
    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid[DIV_STEPS] && !o_ready |=> dv_valid[DIV_STEPS])
        else $error("division chain lost a request under stall");

    // input side stays open while the input register is empty
    a_accept_open: assert property (@(posedge clk) disable iff (!rst_n)
        !a_valid_reg |-> s_tready)
        else $error("input closed while input register empty");

endmodule

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for the pipelined fixed-point alu
// depends on fpa_pkg and fixed_point_alu; predicts each result and compares in order
`timescale 1ns / 1ps

module tb_top;
    import fpa_pkg::*;

    localparam int FB      = FRAC_BITS_DEF;
    localparam int LATENCY = 36;

    // opcode left unused by the block
    localparam logic [3:0] CMD_UNUSED = 4'd15;

    // result fields as they leave the block, highest bit first
    typedef struct packed {
        logic        dz;
        logic        ov;
        logic        cmp;
        logic [31:0] value;
    } alu_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    alu_result_t pending_results[$];
    int          error_count;
    bit          hold_off;      // long receiver hold-off requested
    bit          stall_enable;  // random receiver stalls on or off

    fixed_point_alu #(.FRAC_BITS(FB)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // clamp a wide signed value into the 32-bit range
    function automatic logic [31:0] clamp32(input logic signed [71:0] v, inout logic ov);
        if (v > 72'sd2147483647)
        begin
            ov = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -72'sd2147483648)
        begin
            ov = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // exact-integer model of one alu operation
    function automatic alu_result_t compute_alu(input cmd_t op, input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        alu_result_t r;
        logic signed [71:0] wa, wb, q;
        logic [71:0] ma, mb, num, mq;
        logic ov;
        logic neg;
        r = '0;
        ov = 1'b0;
        wa = a;
        wb = b;
        ma = (wa < 0) ? -wa : wa;
        mb = (wb < 0) ? -wb : wb;
        neg = (a < 0) != (b < 0);
        case (op)
            CMD_ADD:  r.value = clamp32(wa + wb, ov);
            CMD_SUB:  r.value = clamp32(wa - wb, ov);
            CMD_MUL:
            begin
                mq = (ma * mb + (72'd1 << (FB - 1))) >> FB;
                q = neg ? -$signed(mq) : $signed(mq);
                r.value = clamp32(q, ov);
            end
            CMD_DIV:
            begin
                if (b == 0)
                begin
                    r.dz = 1'b1;
                    r.value = (a < 0) ? SAT_MIN : SAT_MAX;
                end
                else
                begin
                    num = ma << FB;
                    mq = (2 * num + mb) / (2 * mb);
                    q = neg ? -$signed(mq) : $signed(mq);
                    r.value = clamp32(q, ov);
                end
            end
            CMD_EQ:   r.cmp = a == b;
            CMD_NE:   r.cmp = a != b;
            CMD_LT:   r.cmp = a < b;
            CMD_LE:   r.cmp = a <= b;
            CMD_GT:   r.cmp = a > b;
            CMD_GE:   r.cmp = a >= b;
            CMD_MIN:  r.value = (a > b) ? b : a;
            CMD_MAX:  r.value = (a < b) ? b : a;
            CMD_INCR: r.value = clamp32(wa + 1, ov);
            CMD_FROM_INT: r.value = clamp32(wa * (72'sd1 <<< FB), ov);
            CMD_TO_INT:   r.value = a >>> FB;
            default:  r = '0;
        endcase
        r.ov = ov;
        return r;
    endfunction

    // send one request, hold it until accepted, queue the expected result
    task automatic send_request(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, b, a, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == CMD_UNUSED)
            pending_results.push_back('0);
        else
            pending_results.push_back(compute_alu(cmd_t'(op), a, b));
    endtask

    task automatic idle_cycles(input int n);
        s_tvalid <= 1'b0;
        repeat (n)
            @(posedge clk);
    endtask

    // wait until every expected result has come back
    task automatic drain_results;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // random operand biased toward edge values
    function automatic logic [31:0] pick_operand;
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
            1: return 32'h8000_0000 + $urandom_range(0, 2);
            2: return $urandom_range(0, 4) - 2;
            3: return $urandom_range(0, 2047) - 1024;
            4: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed;
        cmd_t op;
        op = op.first();
        do
        begin
            send_request(op, 32'h7FFF_FFFF, 32'h8000_0000);
            send_request(op, 32'h0000_0180, 32'hFFFF_FF80);
            op = op.next();
        end
        while (op != op.first());
        // divide by zero for both signs, rounding halves, increment at the maximum, unused opcode
        send_request(CMD_DIV, 32'h0000_0100, 32'h0);
        send_request(CMD_DIV, 32'h8000_0000, 32'h0);
        send_request(CMD_MUL, 32'h0000_0001, 32'h0000_0080);
        send_request(CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0080);
        send_request(CMD_INCR, 32'h7FFF_FFFF, 32'h0);
        send_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic test_random(input int count);
        int burst;
        int sent;
        logic [31:0] a, b;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                a = pick_operand();
                b = ($urandom_range(0, 7) == 0) ? a : pick_operand();
                send_request(($urandom_range(0, 40) == 0) ? CMD_UNUSED
                                                          : 4'($urandom_range(0, 14)),
                             a, b);
                sent++;
            end
            if ($urandom_range(0, 2) == 0)
                idle_cycles($urandom_range(1, 6));
        end
    endtask

    // receiver held off while the sender keeps offering requests
    task automatic test_backpressure;
        hold_off = 1'b1;
        repeat (120)
            send_request(4'($urandom_range(0, 14)), pick_operand(), pick_operand());
        wait (hold_off == 1'b0);
        drain_results();
    endtask

    // receiver ready pattern: random stalls, long hold-off on request
    initial
    begin
        int hold;
        m_tready = 1'b0;
        hold_off = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                for (hold = 0; hold < 200; hold++)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            m_tready <= stall_enable ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        alu_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[34:0];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected value %h cmp %b ov %b dz %b",
                             $time, want.value, want.cmp, want.ov, want.dz);
                    $display("%0t:          actual   value %h cmp %b ov %b dz %b",
                             $time, got.value, got.cmp, got.ov, got.dz);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        error_count = 0;
        stall_enable = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        stall_enable = 1'b1;
        test_random(800);
        test_backpressure();
        stall_enable = 1'b0;
        test_random(400);
        stall_enable = 1'b1;
        test_random(500);
        drain_results();
        repeat (LATENCY + 4)
            @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
